// ===== rtl/core/hbad_pkg.sv =====
package hbad_pkg;

  localparam int unsigned WorkRamBytesDef = 262144;
  localparam int unsigned IoSpaceBytesDef = 1024;

  typedef enum logic [3:0] {
    TGT_NONE = 4'd0,
    TGT_WRAM = 4'd1,
    TGT_IRAM = 4'd2,
    TGT_IO   = 4'd3,
    TGT_PAL  = 4'd4,
    TGT_VRAM = 4'd5,
    TGT_OAM  = 4'd6,
    TGT_BIOS = 4'd7,
    TGT_CART = 4'd8
  } target_t;

  typedef enum logic [3:0] {
    ACT_DROP     = 4'd0,
    ACT_READ     = 4'd1,
    ACT_WRITE    = 4'd2,
    ACT_IO_WRITE = 4'd3,
    ACT_IO_MERGE = 4'd4,
    ACT_SOUND    = 4'd5,
    ACT_HALT     = 4'd6,
    ACT_STOP     = 4'd7,
    ACT_EXT      = 4'd8
  } action_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0]  LastTextMode   = 3'd2;
  localparam logic [9:0]  IoHaltAddr     = 10'h301;
  localparam logic [7:0]  StopByte       = 8'h80;
  localparam logic [16:0] VramBlankMask  = 17'h1C000;
  localparam logic [16:0] VramBlankBase  = 17'h18000;
  localparam logic [16:0] VramMirrorMask = 17'h18000;
  localparam logic [16:0] VramMirrorKeep = 17'h17FFF;
  localparam logic [16:0] ObjLimitText   = 17'h10000;
  localparam logic [16:0] ObjLimitBitmap = 17'h14000;

  // predecoded access, stage 1
  typedef struct packed {
    logic        wr;
    logic [1:0]  sz;
    target_t     tgt;
    logic [17:0] al;
    logic [9:0]  a_io;
    logic [3:0]  be;
    logic [31:0] dm;
    logic [1:0]  rot;
    logic [16:0] v;
    logic        blank;
    logic        obj_ok;
    logic        io_out;
    logic        io_rd;
    logic        io_rd_hi;
    logic        io_sound;
  } s1_t;

  // resolved result, stage 2
  typedef struct packed {
    target_t     target;
    action_t     action;
    logic [17:0] offset;
    logic [3:0]  ben;
    logic [31:0] store;
    logic [1:0]  rot;
    logic        rzero;
    logic        uhz;
  } res_t;

  function automatic logic io_readable(input logic [9:0] i);
    logic r;
    case (i) inside
      [10'h010:10'h047], [10'h04C:10'h04F], [10'h054:10'h05F], [10'h08C:10'h08F],
      [10'h0A0:10'h0B7], [10'h0BC:10'h0C3], [10'h0C8:10'h0CF], [10'h0D4:10'h0DB],
      [10'h0E0:10'h0FF], [10'h110:10'h11F], [10'h12C:10'h12F], [10'h138:10'h13F],
      [10'h144:10'h14F], [10'h15C:10'h1FF], [10'h20C:10'h2FF], [10'h304:10'h3FF]:
        r = 1'b0;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic is_sound_reg(input logic [9:0] i);
    logic r;
    case (i) inside
      [10'h060:10'h065], [10'h070:10'h075], [10'h090:10'h09F],
      10'h068, 10'h069, 10'h06C, 10'h06D, 10'h078, 10'h079, 10'h07C, 10'h07D,
      10'h080, 10'h081, 10'h084, 10'h085:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/hbad_resolve.sv =====
module hbad_resolve #(
  parameter int unsigned WORK_RAM_BYTES = hbad_pkg::WorkRamBytesDef
) (
  input  hbad_pkg::s1_t  s1,
  output hbad_pkg::res_t res
);
  import hbad_pkg::*;

  localparam logic [17:0] WramMask = 18'(WORK_RAM_BYTES - 1);

  always_comb begin
    res = '0;
    res.target = s1.tgt;
    if (s1.wr == OP_READ) begin
      unique case (s1.tgt)
        TGT_BIOS: begin
          res.action = ACT_EXT;
          res.offset = s1.al & 18'h03FFF;
        end
        TGT_WRAM: begin
          res.action = ACT_READ;
          res.offset = s1.al & WramMask;
        end
        TGT_IRAM: begin
          res.action = ACT_READ;
          res.offset = s1.al & 18'h07FFF;
        end
        TGT_IO: begin
          if (s1.io_out || !s1.io_rd) begin
            res.rzero = 1'b1;
          end else begin
            res.action = ACT_READ;
            res.offset = {8'd0, s1.al[9:0]};
            res.uhz    = (s1.sz == SZ_WORD) && !s1.io_rd_hi;
          end
        end
        TGT_PAL, TGT_OAM: begin
          res.action = ACT_READ;
          res.offset = {8'd0, s1.al[9:0]};
        end
        TGT_VRAM: begin
          if (s1.blank) begin
            res.rzero = 1'b1;
          end else begin
            res.action = ACT_READ;
            res.offset = {1'b0, s1.v};
          end
        end
        TGT_CART: begin
          res.action = ACT_EXT;
          res.offset = s1.al;
        end
        default: res.rzero = 1'b1;
      endcase
      if (res.action != ACT_DROP) begin
        res.ben = s1.be;
        res.rot = s1.rot;
      end
    end else begin
      res.ben   = s1.be;
      res.store = s1.dm;
      unique case (s1.tgt)
        TGT_WRAM: begin
          res.action = ACT_WRITE;
          res.offset = s1.al & WramMask;
        end
        TGT_IRAM: begin
          res.action = ACT_WRITE;
          res.offset = s1.al & 18'h07FFF;
        end
        TGT_IO: begin
          if (!s1.io_out) begin
            if (s1.sz != SZ_BYTE) begin
              res.action = ACT_IO_WRITE;
              res.offset = {8'd0, s1.al[9:0]};
            end else if (s1.io_sound) begin
              res.action = ACT_SOUND;
              res.offset = {8'd0, s1.a_io};
            end else if (s1.a_io == IoHaltAddr) begin
              res.action = (s1.dm[7:0] == StopByte) ? ACT_STOP : ACT_HALT;
              res.offset = {8'd0, s1.a_io};
            end else begin
              res.action = ACT_IO_MERGE;
              res.offset = {8'd0, s1.a_io[9:1], 1'b0};
            end
          end
        end
        TGT_PAL: begin
          res.action = ACT_WRITE;
          if (s1.sz == SZ_BYTE) begin
            // byte store lands as a replicated halfword
            res.offset = {8'd0, s1.a_io[9:1], 1'b0};
            res.store  = {16'd0, s1.dm[7:0], s1.dm[7:0]};
            res.ben    = s1.a_io[1] ? 4'b1100 : 4'b0011;
          end else begin
            res.offset = {8'd0, s1.al[9:0]};
          end
        end
        TGT_VRAM: begin
          if (s1.sz == SZ_BYTE) begin
            if (!s1.blank && s1.obj_ok) begin
              res.action = ACT_WRITE;
              res.offset = {1'b0, s1.v[16:1], 1'b0};
              res.store  = {16'd0, s1.dm[7:0], s1.dm[7:0]};
              res.ben    = s1.a_io[1] ? 4'b1100 : 4'b0011;
            end
          end else if (!s1.blank) begin
            res.action = ACT_WRITE;
            res.offset = {1'b0, s1.v};
          end
        end
        TGT_OAM: begin
          if (s1.sz != SZ_BYTE) begin
            res.action = ACT_WRITE;
            res.offset = {8'd0, s1.al[9:0]};
          end
        end
        TGT_CART: begin
          res.action = ACT_EXT;
          res.offset = s1.al;
        end
        default: res.action = ACT_DROP;
      endcase
      if (res.action == ACT_DROP) begin
        res.offset = '0;
        res.ben    = '0;
        res.store  = '0;
      end
    end
  end

endmodule

// ===== rtl/core/handheld_bus_access_decoder.sv =====
// Bus access decoder for a handheld console memory map.
// Input channel: in_valid/in_stall with op, access_size, bus_address and
// write_data; one beat is one CPU access. Output channel: out_valid/out_stall
// with target, action, offset, byte_enable, store_value, rotate_bytes,
// read_zero and upper_half_zero; exactly one result beat per input beat, in
// order.
// An access passes from input beat to result beat through a predecode stage
// (region, alignment, vram mirroring, io readability lookups), a resolve stage
// and the output register. Throughput is one access per cycle while the output is not stalled.
// A stall on the output holds the result register; stages behind it keep
// filling until each one holds a beat, so in_stall rises only once the
// pipeline is full. Nothing is dropped or repeated.
// The video_mode register is written through cfg_write_en/cfg_write_data and
// should only change while no access is in flight.
// Synchronous reset empties the pipeline and sets video_mode to zero.
module handheld_bus_access_decoder #(
  parameter int unsigned WORK_RAM_BYTES = hbad_pkg::WorkRamBytesDef,
  parameter int unsigned IO_SPACE_BYTES = hbad_pkg::IoSpaceBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [1:0]  access_size,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  target,
  output logic [3:0]  action,
  output logic [17:0] offset,
  output logic [3:0]  byte_enable,
  output logic [31:0] store_value,
  output logic [1:0]  rotate_bytes,
  output logic        read_zero,
  output logic        upper_half_zero
);
  import hbad_pkg::*;

  logic [2:0] video_mode;

  s1_t  s1_next;
  s1_t  s1;
  logic v1;
  res_t res_next;
  res_t s2;
  logic v2;
  logic rdy1, rdy2, rdy3;

  logic [1:0]  sz;
  logic [16:0] v0;
  logic        bitmap;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      video_mode <= '0;
    end else if (cfg_write_en) begin
      video_mode <= cfg_write_data;
    end
  end

  // predecode
  assign sz     = (access_size == 2'd3) ? SZ_WORD : access_size;
  assign bitmap = video_mode > LastTextMode;
  // aligned low address bits, same as the stage 1 aligned address
  assign v0     = {bus_address[16:2], (sz != SZ_WORD) && bus_address[1],
                   (sz == SZ_BYTE) && bus_address[0]};

  always_comb begin
    s1_next      = '0;
    s1_next.wr   = op;
    s1_next.sz   = sz;
    s1_next.a_io = bus_address[9:0];
    case (sz)
      SZ_WORD: begin
        s1_next.al  = {bus_address[17:2], 2'b00};
        s1_next.be  = 4'hF;
        s1_next.dm  = write_data;
        s1_next.rot = bus_address[1:0];
      end
      SZ_HALF: begin
        s1_next.al  = {bus_address[17:1], 1'b0};
        s1_next.be  = bus_address[1] ? 4'b1100 : 4'b0011;
        s1_next.dm  = {16'd0, write_data[15:0]};
        s1_next.rot = {1'b0, bus_address[0]};
      end
      default: begin
        s1_next.al  = bus_address[17:0];
        s1_next.be  = 4'b0001 << bus_address[1:0];
        s1_next.dm  = {24'd0, write_data[7:0]};
        s1_next.rot = 2'd0;
      end
    endcase
    unique case (bus_address[31:24]) inside
      8'h00:          s1_next.tgt = TGT_BIOS;
      8'h02:          s1_next.tgt = TGT_WRAM;
      8'h03:          s1_next.tgt = TGT_IRAM;
      8'h04:          s1_next.tgt = TGT_IO;
      8'h05:          s1_next.tgt = TGT_PAL;
      8'h06:          s1_next.tgt = TGT_VRAM;
      8'h07:          s1_next.tgt = TGT_OAM;
      [8'h08:8'h0E]:  s1_next.tgt = TGT_CART;
      default:        s1_next.tgt = TGT_NONE;
    endcase
    s1_next.blank = bitmap && ((v0 & VramBlankMask) == VramBlankBase);
    // upper 32k of vram mirrors the 96k..128k window down
    s1_next.v = ((v0 & VramMirrorMask) == VramMirrorMask) ? (v0 & VramMirrorKeep) : v0;
    s1_next.obj_ok   = {s1_next.v[16:1], 1'b0} < (bitmap ? ObjLimitBitmap : ObjLimitText);
    s1_next.io_out   = bus_address[23:0] >= 24'(IO_SPACE_BYTES);
    s1_next.io_rd    = io_readable(s1_next.al[9:0]);
    s1_next.io_rd_hi = io_readable(s1_next.al[9:0] + 10'd2);
    s1_next.io_sound = is_sound_reg(bus_address[9:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1 <= s1_next;
    end
  end

  hbad_resolve #(
    .WORK_RAM_BYTES(WORK_RAM_BYTES)
  ) u_resolve (
    .s1  (s1),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2 <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      target          <= s2.target;
      action          <= s2.action;
      offset          <= s2.offset;
      byte_enable     <= s2.ben;
      store_value     <= s2.store;
      rotate_bytes    <= s2.rot;
      read_zero       <= s2.rzero;
      upper_half_zero <= s2.uhz;
    end
  end

`ifndef SYNTH
  a_rzero_drops: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_zero |-> action == ACT_DROP)
    else $error("zero read carries an action");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_DROP |->
      offset == '0 && byte_enable == '0 && rotate_bytes == '0)
    else $error("dropped access has live fields");

  a_uhz_io_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && upper_half_zero |-> action == ACT_READ && target == TGT_IO)
    else $error("upper half clear outside io read");

  a_read_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_READ |-> store_value == '0)
    else $error("read carries store data");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && out_valid && out_stall)
    else $error("input stalled with room in pipeline");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import hbad_pkg::*;

  localparam int WatchdogLimit = 200;
  localparam int PhaseItems = 135;
  localparam logic [23:0] IoSpan = 24'd1024;

  typedef struct packed {
    target_t     target;
    action_t     action;
    logic [17:0] offset;
    logic [3:0]  lanes;
    logic [31:0] store;
    logic [1:0]  rot;
    logic        rzero;
    logic        uhz;
  } decode_t;

  class decode_scoreboard;
    logic [2:0]  video_mode;
    decode_t     pending_decodes[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      video_mode = 3'd0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit io_readable(logic [9:0] ofs);
      return !((ofs >= 10'h010 && ofs < 10'h048) || (ofs >= 10'h04C && ofs < 10'h050) ||
               (ofs >= 10'h054 && ofs < 10'h060) || (ofs >= 10'h08C && ofs < 10'h090) ||
               (ofs >= 10'h0A0 && ofs < 10'h0B8) || (ofs >= 10'h0BC && ofs < 10'h0C4) ||
               (ofs >= 10'h0C8 && ofs < 10'h0D0) || (ofs >= 10'h0D4 && ofs < 10'h0DC) ||
               (ofs >= 10'h0E0 && ofs < 10'h100) || (ofs >= 10'h110 && ofs < 10'h120) ||
               (ofs >= 10'h12C && ofs < 10'h130) || (ofs >= 10'h138 && ofs < 10'h140) ||
               (ofs >= 10'h144 && ofs < 10'h150) || (ofs >= 10'h15C && ofs < 10'h200) ||
               (ofs >= 10'h20C && ofs < 10'h300) || (ofs >= 10'h304));
    endfunction

    function bit sound_reg(logic [9:0] ofs);
      case (ofs)
        10'h068, 10'h069, 10'h06C, 10'h06D, 10'h078, 10'h079, 10'h07C, 10'h07D,
        10'h080, 10'h081, 10'h084, 10'h085:
          return 1'b1;
        default:
          return (ofs >= 10'h060 && ofs <= 10'h065) || (ofs >= 10'h070 && ofs <= 10'h075) ||
                 (ofs >= 10'h090 && ofs <= 10'h09F);
      endcase
    endfunction

    function decode_t decode_access(logic wr, logic [1:0] size, logic [31:0] addr,
                                    logic [31:0] data);
      decode_t     r;
      logic [1:0]  sz;
      logic [31:0] al;
      logic [3:0]  lanes;
      logic [31:0] dm;
      logic [1:0]  rot;
      logic [7:0]  b;
      logic [16:0] v;
      logic [16:0] limit;
      logic [9:0]  io;
      logic        blank;
      logic        io_out;
      r = '0;
      sz = (size == 2'd3) ? SZ_WORD : size;
      case (sz)
        SZ_WORD: begin
          al = {addr[31:2], 2'b00};
          lanes = 4'b1111;
          dm = data;
          rot = addr[1:0];
        end
        SZ_HALF: begin
          al = {addr[31:1], 1'b0};
          lanes = 4'b0011 << {addr[1], 1'b0};
          dm = {16'h0, data[15:0]};
          rot = {1'b0, addr[0]};
        end
        default: begin
          al = addr;
          lanes = 4'b0001 << addr[1:0];
          dm = {24'h0, data[7:0]};
          rot = 2'd0;
        end
      endcase
      b = data[7:0];
      v = al[16:0];
      // bitmap modes hide the vram window at 96k..112k before mirroring
      blank = video_mode > 3'd2 && (v & 17'h1C000) == 17'h18000;
      if ((v & 17'h18000) == 17'h18000) v = v & 17'h17FFF;
      io_out = addr[23:0] >= IoSpan;
      io = addr[9:0];

      if (wr == OP_READ) begin
        case (addr[31:24])
          8'h00: begin
            r.target = TGT_BIOS; r.action = ACT_EXT; r.offset = {4'h0, al[13:0]};
          end
          8'h02: begin
            r.target = TGT_WRAM; r.action = ACT_READ;
            r.offset = 18'(al & (WorkRamBytesDef - 1));
          end
          8'h03: begin
            r.target = TGT_IRAM; r.action = ACT_READ; r.offset = {3'h0, al[14:0]};
          end
          8'h04: begin
            r.target = TGT_IO;
            if (io_out || !io_readable(al[9:0])) begin
              r.rzero = 1'b1;
            end else begin
              r.action = ACT_READ;
              r.offset = {8'h0, al[9:0]};
              if (sz == SZ_WORD && !io_readable(al[9:0] + 10'd2)) r.uhz = 1'b1;
            end
          end
          8'h05: begin
            r.target = TGT_PAL; r.action = ACT_READ; r.offset = {8'h0, al[9:0]};
          end
          8'h06: begin
            r.target = TGT_VRAM;
            if (blank) r.rzero = 1'b1;
            else begin
              r.action = ACT_READ; r.offset = {1'b0, v};
            end
          end
          8'h07: begin
            r.target = TGT_OAM; r.action = ACT_READ; r.offset = {8'h0, al[9:0]};
          end
          8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E: begin
            r.target = TGT_CART; r.action = ACT_EXT; r.offset = al[17:0];
          end
          default: r.rzero = 1'b1;
        endcase
        if (r.action != ACT_DROP) begin
          r.lanes = lanes;
          r.rot = rot;
        end
      end else begin
        r.lanes = lanes;
        r.store = dm;
        case (addr[31:24])
          8'h00: r.target = TGT_BIOS;
          8'h02: begin
            r.target = TGT_WRAM; r.action = ACT_WRITE;
            r.offset = 18'(al & (WorkRamBytesDef - 1));
          end
          8'h03: begin
            r.target = TGT_IRAM; r.action = ACT_WRITE; r.offset = {3'h0, al[14:0]};
          end
          8'h04: begin
            r.target = TGT_IO;
            if (!io_out) begin
              if (sz != SZ_BYTE) begin
                r.action = ACT_IO_WRITE; r.offset = {8'h0, al[9:0]};
              end else if (sound_reg(io)) begin
                r.action = ACT_SOUND; r.offset = {8'h0, io};
              end else if (io == 10'h301) begin
                r.action = (b == 8'h80) ? ACT_STOP : ACT_HALT;
                r.offset = {8'h0, io};
              end else begin
                r.action = ACT_IO_MERGE; r.offset = {8'h0, io[9:1], 1'b0};
              end
            end
          end
          8'h05: begin
            r.target = TGT_PAL; r.action = ACT_WRITE;
            if (sz == SZ_BYTE) begin
              r.offset = {8'h0, addr[9:1], 1'b0};
              r.store = {16'h0, b, b};
              r.lanes = 4'b0011 << {addr[1], 1'b0};
            end else begin
              r.offset = {8'h0, al[9:0]};
            end
          end
          8'h06: begin
            r.target = TGT_VRAM;
            if (sz == SZ_BYTE) begin
              // byte writes stop at the obj tile area
              limit = (video_mode > 3'd2) ? 17'h14000 : 17'h10000;
              v = {v[16:1], 1'b0};
              if (!blank && v < limit) begin
                r.action = ACT_WRITE;
                r.offset = {1'b0, v};
                r.store = {16'h0, b, b};
                r.lanes = 4'b0011 << {addr[1], 1'b0};
              end
            end else if (!blank) begin
              r.action = ACT_WRITE; r.offset = {1'b0, v};
            end
          end
          8'h07: begin
            r.target = TGT_OAM;
            if (sz != SZ_BYTE) begin
              r.action = ACT_WRITE; r.offset = {8'h0, al[9:0]};
            end
          end
          8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E: begin
            r.target = TGT_CART; r.action = ACT_EXT; r.offset = al[17:0];
          end
          default: ;
        endcase
        if (r.action == ACT_DROP) begin
          r.offset = '0;
          r.lanes = '0;
          r.store = '0;
        end
      end
      return r;
    endfunction

    function void note_access(logic wr, logic [1:0] size, logic [31:0] addr,
                              logic [31:0] data);
      pending_decodes.push_back(decode_access(wr, size, addr, data));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (mismatches < 10)
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 results_seen, field, want, got);
      mismatches++;
    endfunction

    function void check_result(decode_t got);
      decode_t want;
      if (pending_decodes.size() == 0) begin
        if (mismatches < 10) $display("result beat %0d arrived with nothing pending", results_seen);
        mismatches++;
        results_seen++;
        return;
      end
      want = pending_decodes.pop_front();
      if (want.target !== got.target) report("target", want.target, got.target);
      if (want.action !== got.action) report("action", want.action, got.action);
      if (want.offset !== got.offset) report("offset", want.offset, got.offset);
      if (want.lanes !== got.lanes) report("byte_enable", want.lanes, got.lanes);
      if (want.store !== got.store) report("store_value", want.store, got.store);
      if (want.rot !== got.rot) report("rotate_bytes", want.rot, got.rot);
      if (want.rzero !== got.rzero) report("read_zero", want.rzero, got.rzero);
      if (want.uhz !== got.uhz) report("upper_half_zero", want.uhz, got.uhz);
      results_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_write_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_READ;
  logic [1:0]  access_size = SZ_BYTE;
  logic [31:0] bus_address = 32'h0;
  logic [31:0] write_data = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  target;
  logic [3:0]  action;
  logic [17:0] offset;
  logic [3:0]  byte_enable;
  logic [31:0] store_value;
  logic [1:0]  rotate_bytes;
  logic        read_zero;
  logic        upper_half_zero;

  decode_scoreboard sb;
  decode_t          beat_seen;
  int               in_quiet = 0;
  int               out_quiet = 0;
  int               idle_cycles = 0;
  int               accesses_sent = 0;
  int               mode_writes = 0;
  logic [2:0]       mode_plan [10] = '{3'd7, 3'd0, 3'd3, 3'd2, 3'd5,
                                       3'd1, 3'd6, 3'd4, 3'd0, 3'd7};

  handheld_bus_access_decoder DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .access_size     (access_size),
    .bus_address     (bus_address),
    .write_data      (write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .target          (target),
    .action          (action),
    .offset          (offset),
    .byte_enable     (byte_enable),
    .store_value     (store_value),
    .rotate_bytes    (rotate_bytes),
    .read_zero       (read_zero),
    .upper_half_zero (upper_half_zero)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // wait cycles per beat, with occasional runs of back-to-back beats
  function automatic int pick_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet = $urandom_range(8, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_access(input logic wr, input logic [1:0] sz, input logic [31:0] addr,
                             input logic [31:0] data);
    int gap;
    gap = pick_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= wr;
    access_size <= sz;
    bus_address <= addr;
    write_data <= data;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_access(wr, sz, addr, data);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic set_video_mode(input logic [2:0] mode);
    in_valid <= 1'b0;
    while (sb.pending_decodes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= mode;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.video_mode = mode;
    mode_writes++;
  endtask

  task automatic random_access();
    logic        wr;
    logic [1:0]  sz;
    logic [31:0] addr;
    logic [31:0] data;
    int          pick;
    wr = 1'($urandom_range(0, 1));
    sz = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    addr = $urandom;
    data = $urandom;
    pick = $urandom_range(0, 19);
    case (pick)
      0: addr[31:24] = 8'h00;
      1: addr[31:24] = 8'h01;
      2: addr[31:24] = 8'h02;
      3: addr[31:24] = 8'h03;
      4, 5, 6, 7: begin
        // keep most io beats inside the register space
        addr[31:10] = 22'h010000;
        if ($urandom_range(0, 7) == 0) addr[9:0] = 10'h301;
        else if ($urandom_range(0, 3) == 0) addr[9:0] = 10'h060 + 10'($urandom_range(0, 63));
      end
      8: addr[31:24] = 8'h05;
      9, 10, 11, 12: addr[31:24] = 8'h06;
      13: addr[31:24] = 8'h07;
      14, 15, 16: addr[31:24] = 8'h08 + 8'($urandom_range(0, 6));
      17: addr[31:24] = 8'h0F;
      18: ;
      default: addr[31:24] = 8'h04;
    endcase
    if ($urandom_range(0, 9) == 0) data[7:0] = 8'h80;
    send_access(wr, sz, addr, data);
  endtask

  // result side: sample at the rising edge, drive stall at the falling edge
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        beat_seen = {target, action, offset, byte_enable, store_value, rotate_bytes,
                     read_zero, upper_half_zero};
        sb.check_result(beat_seen);
        hold = pick_wait(out_quiet);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("no beat moved for %0d cycles, %0d results still pending",
                 idle_cycles, sb.pending_decodes.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_video_mode(3'd0);
    send_access(OP_READ, SZ_WORD, 32'h0000_0003, 32'h0);
    send_access(OP_WRITE, SZ_BYTE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(OP_READ, SZ_HALF, 32'h0100_0001, 32'h0);
    send_access(OP_WRITE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_READ, 2'd3, 32'h02FF_FFFE, 32'h0);
    send_access(OP_WRITE, SZ_HALF, 32'h0300_7FFF, 32'h1234_ABCD);
    send_access(OP_READ, SZ_WORD, 32'h0400_0012, 32'h0);
    send_access(OP_READ, SZ_WORD, 32'h0400_0302, 32'h0);
    send_access(OP_READ, SZ_HALF, 32'h0400_0400, 32'h0);
    send_access(OP_WRITE, SZ_BYTE, 32'h0400_0065, 32'h0000_0011);
    send_access(OP_WRITE, SZ_BYTE, 32'h0400_0301, 32'h0000_0080);
    send_access(OP_WRITE, SZ_BYTE, 32'h0400_0301, 32'h0000_007F);
    send_access(OP_WRITE, SZ_BYTE, 32'h0400_0123, 32'h0000_00C3);
    send_access(OP_WRITE, SZ_WORD, 32'h0400_0208, 32'hDEAD_BEEF);
    send_access(OP_WRITE, SZ_BYTE, 32'h04FF_FFFF, 32'h0000_0055);
    send_access(OP_WRITE, SZ_BYTE, 32'h0500_03FF, 32'h0000_00AB);
    send_access(OP_WRITE, SZ_BYTE, 32'h0601_0001, 32'h0000_005A);
    send_access(OP_WRITE, SZ_BYTE, 32'h0600_FFFF, 32'h0000_00A5);
    send_access(OP_READ, SZ_HALF, 32'h0601_8001, 32'h0);
    send_access(OP_WRITE, SZ_BYTE, 32'h0700_0001, 32'h0000_0077);
    send_access(OP_WRITE, SZ_HALF, 32'h0700_0402, 32'h0000_BEEF);
    send_access(OP_READ, SZ_WORD, 32'h0800_0003, 32'h0);
    send_access(OP_WRITE, SZ_BYTE, 32'h0EFF_FFFF, 32'h8765_4321);
    send_access(OP_READ, SZ_BYTE, 32'h0F00_0000, 32'h0);

    // bitmap mode: blank window and the raised tile limit
    set_video_mode(3'd7);
    send_access(OP_READ, SZ_WORD, 32'h0601_8000, 32'h0);
    send_access(OP_WRITE, SZ_BYTE, 32'h0601_3FFF, 32'h0000_0033);
    send_access(OP_WRITE, SZ_BYTE, 32'h0601_4000, 32'h0000_0044);

    for (int p = 0; p < 10; p++) begin
      set_video_mode(mode_plan[p]);
      for (int i = 0; i < PhaseItems; i++) random_access();
    end

    in_valid <= 1'b0;
    while (sb.pending_decodes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("decoded %0d accesses of every size and region over %0d video mode writes",
             accesses_sent, mode_writes);
    $display("%0d result beats checked under random gaps and back-pressure, %0d mismatches",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hbad_pkg.sv
rtl/core/hbad_resolve.sv
rtl/core/handheld_bus_access_decoder.sv
tb/sv/tb.sv
